// ===== sv/xxb_pkg.sv =====
`default_nettype none
package xxb_pkg;

  localparam int unsigned MAX_WORDS_DEF = 64;
  localparam logic [31:0] GOLDEN = 32'h9e37_79b9;
  localparam int unsigned KEY_WORDS = 4;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY0 = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY1 = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY3 = 2'd3;

  typedef logic [KEY_WORDS-1:0][31:0] key_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SETUP,
    ST_PRE_A,
    ST_PRE_B,
    ST_PRE_C,
    ST_READ,
    ST_MIX,
    ST_WRITE,
    ST_OUT_READ,
    ST_OUT_LOAD
  } state_t;

  // Control from the sequencer to the mixing datapath
  typedef struct packed {
    logic       load;
    logic       decrypt;
    logic [1:0] pos_low;
  } mix_ctl_t;

  // Full rounds for a block of n words: 6 + 52/n, for n from 2 upwards
  function automatic logic [5:0] rounds_for(input logic [6:0] n);
    logic [5:0] r;
    r = 6'd6;
    if (n <= 7'd2) begin
      r = 6'd32;
    end else if (n == 7'd3) begin
      r = 6'd23;
    end else if (n == 7'd4) begin
      r = 6'd19;
    end else if (n == 7'd5) begin
      r = 6'd16;
    end else if (n == 7'd6) begin
      r = 6'd14;
    end else if (n == 7'd7) begin
      r = 6'd13;
    end else if (n == 7'd8) begin
      r = 6'd12;
    end else if (n <= 7'd10) begin
      r = 6'd11;
    end else if (n <= 7'd13) begin
      r = 6'd10;
    end else if (n <= 7'd17) begin
      r = 6'd9;
    end else if (n <= 7'd26) begin
      r = 6'd8;
    end else if (n <= 7'd52) begin
      r = 6'd7;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/xxb_in_if.sv =====
`default_nettype none
interface xxb_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] data_word;
  logic        last_word;

  modport source (output valid, output mode, output data_word, output last_word,
                  input ready);
  modport sink (input valid, input mode, input data_word, input last_word,
                output ready);
endinterface
`default_nettype wire

// ===== sv/xxb_out_if.sv =====
`default_nettype none
interface xxb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_word;
  logic        last_result;

  modport source (output valid, output result_word, output last_result, input ready);
  modport sink (input valid, input result_word, input last_result, output ready);
endinterface
`default_nettype wire

// ===== sv/xxb_word_ram.sv =====
`default_nettype none
module xxb_word_ram import xxb_pkg::*; #(
  parameter int unsigned DEPTH = MAX_WORDS_DEF,
  parameter int unsigned AW = $clog2(MAX_WORDS_DEF)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [31:0]   wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic [31:0]        rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-first, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== sv/xxb_mix_unit.sv =====
`default_nettype none
module xxb_mix_unit import xxb_pkg::*; (
  input  wire logic        clk,
  input  wire mix_ctl_t    ctl,
  input  wire logic [31:0] fetched,
  input  wire logic [31:0] other,
  input  wire logic [31:0] cur,
  input  wire logic [31:0] sum,
  input  wire key_t        key,
  output logic [31:0]      new_word
);

  logic [31:0] y;
  logic [31:0] z;
  logic [1:0]  key_sel;
  logic [31:0] mix_val;
  logic [31:0] mix_q;

  always_comb begin
    y       = ctl.decrypt ? other : fetched;
    z       = ctl.decrypt ? fetched : other;
    key_sel = ctl.pos_low ^ sum[3:2];
    mix_val = (((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4))) ^
              ((sum ^ y) + (key[key_sel] ^ z));
  end

  // hold the mix term for the update cycle
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mix_q <= mix_val;
    end
  end

  assign new_word = ctl.decrypt ? (cur - mix_q) : (cur + mix_q);

endmodule
`default_nettype wire

// ===== sv/xxtea_block_cipher.sv =====
`default_nettype none
// Load: one input word per cycle. Compute: set-up states SETUP, PRE_A, PRE_B, PRE_C, then
// READ, MIX and WRITE per mixing step (set by the store's single read port and write-back).
// Output: words are read in OUT_READ and registered in OUT_LOAD, the next once the last is taken.
// One block is handled at a time. Reset (rst, synchronous) clears the key, the word count,
// mode and the sequencer; the word store is left undefined and needs no clearing pass.
module xxtea_block_cipher import xxb_pkg::*; #(
  parameter int unsigned MAX_WORDS = MAX_WORDS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  xxb_in_if.sink                      in_chan,
  xxb_out_if.source                   out_chan,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]            cfg_data
);

  localparam int unsigned AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_WORDS + 1);

  state_t        state;
  state_t        state_next;
  key_t          key;
  logic [CW-1:0] count;
  logic          block_mode;
  logic [5:0]    rounds_left;
  logic [31:0]   sum;
  logic [AW-1:0] pos;
  logic [AW-1:0] out_idx;
  logic [31:0]   cur;
  logic [31:0]   other;
  logic [31:0]   data_q;
  logic [31:0]   out_word;
  logic          out_last;
  logic          out_valid;

  logic          in_xfer;
  logic          out_xfer;
  logic          store_word;
  logic [CW-1:0] count_after;
  logic [AW-1:0] last_idx;
  logic          step_last;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_data;
  logic [31:0]   new_word;
  logic [5:0]    block_rounds;
  mix_ctl_t      mix_ctl;

  assign in_xfer     = in_chan.valid && in_chan.ready;
  assign out_xfer    = out_chan.valid && out_chan.ready;
  assign store_word  = (count < CW'(MAX_WORDS));
  assign count_after = store_word ? (count + 1'b1) : count;
  assign last_idx    = AW'(count - 1'b1);
  // the final step of a full cycle: top position going up, position zero going down
  assign step_last   = block_mode ? (pos == '0) : (pos == last_idx);
  assign block_rounds = rounds_for(7'(count));

  assign in_chan.ready        = (state == ST_LOAD);
  assign out_chan.valid       = out_valid;
  assign out_chan.result_word = out_word;
  assign out_chan.last_result = out_last;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY0: key[0] <= cfg_data;
        REG_KEY1: key[1] <= cfg_data;
        REG_KEY2: key[2] <= cfg_data;
        REG_KEY3: key[3] <= cfg_data;
        default:  key[0] <= key[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state, store addressing and mixing control
  always_comb begin
    state_next      = state;
    wr_en           = 1'b0;
    wr_addr         = pos;
    wr_data         = new_word;
    rd_addr         = pos;
    mix_ctl.load    = 1'b0;
    mix_ctl.decrypt = block_mode;
    mix_ctl.pos_low = 2'(pos);
    case (state)
      ST_LOAD: begin
        wr_addr = AW'(count);
        wr_data = in_chan.data_word;
        wr_en   = in_xfer && store_word;
        if (in_xfer && in_chan.last_word) begin
          state_next = (count_after > 1) ? ST_SETUP : ST_OUT_READ;
        end
      end
      ST_SETUP: begin
        state_next = ST_PRE_A;
      end
      ST_PRE_A: begin
        // fetch z for encryption, y for decryption
        rd_addr    = block_mode ? '0 : last_idx;
        state_next = ST_PRE_B;
      end
      ST_PRE_B: begin
        // fetch the first word to be updated
        rd_addr    = block_mode ? last_idx : '0;
        state_next = ST_PRE_C;
      end
      ST_PRE_C: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        if (block_mode) begin
          rd_addr = (pos == '0) ? last_idx : (pos - 1'b1);
        end else begin
          rd_addr = (pos == last_idx) ? '0 : (pos + 1'b1);
        end
        state_next = ST_MIX;
      end
      ST_MIX: begin
        mix_ctl.load = 1'b1;
        state_next   = ST_WRITE;
      end
      ST_WRITE: begin
        wr_en = 1'b1;
        if (step_last && (rounds_left == 6'd1)) begin
          state_next = ST_OUT_READ;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_OUT_READ: begin
        rd_addr = out_idx;
        if (!out_valid) begin
          state_next = ST_OUT_LOAD;
        end
      end
      ST_OUT_LOAD: begin
        state_next = (out_idx == last_idx) ? ST_LOAD : ST_OUT_READ;
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      block_mode <= 1'b0;
      out_valid  <= 1'b0;
      out_idx    <= '0;
    end else begin
      if (out_xfer) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (in_xfer) begin
            if (count == '0) begin
              block_mode <= in_chan.mode;
            end
            count   <= count_after;
            out_idx <= '0;
          end
        end
        ST_OUT_LOAD: begin
          out_valid <= 1'b1;
          if (out_idx == last_idx) begin
            count <= '0;
          end else begin
            out_idx <= out_idx + 1'b1;
          end
        end
        default: begin
          out_idx <= out_idx;
        end
      endcase
    end
  end

  // round bookkeeping and word registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rounds_left <= '0;
      pos         <= '0;
    end else begin
      case (state)
        ST_SETUP: begin
          rounds_left <= block_rounds;
          pos         <= block_mode ? last_idx : '0;
        end
        ST_WRITE: begin
          if (step_last) begin
            rounds_left <= rounds_left - 1'b1;
            pos         <= block_mode ? last_idx : '0;
          end else begin
            pos <= block_mode ? (pos - 1'b1) : (pos + 1'b1);
          end
        end
        default: begin
          pos <= pos;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_SETUP: begin
        sum <= block_mode ? 32'(32'(block_rounds) * GOLDEN) : GOLDEN;
      end
      ST_PRE_B: begin
        other <= rd_data;
      end
      ST_PRE_C: begin
        cur <= rd_data;
      end
      ST_MIX: begin
        data_q <= rd_data;
      end
      ST_WRITE: begin
        other <= new_word;
        cur   <= data_q;
        if (step_last) begin
          sum <= block_mode ? (sum - GOLDEN) : (sum + GOLDEN);
        end
      end
      ST_OUT_LOAD: begin
        out_word <= rd_data;
        out_last <= (out_idx == last_idx);
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

  xxb_word_ram #(
    .DEPTH (MAX_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  xxb_mix_unit u_mix (
    .clk      (clk),
    .ctl      (mix_ctl),
    .fetched  (rd_data),
    .other    (other),
    .cur      (cur),
    .sum      (sum),
    .key      (key),
    .new_word (new_word)
  );

endmodule
`default_nettype wire
